/* design/salted_dual_fnv_password_kdf_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the salted dual-lane FNV password digest
// Wraps concurrent checks on aclk with reset gating; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SALTED_DUAL_FNV_PASSWORD_KDF_DEFINES_SVH
`define SALTED_DUAL_FNV_PASSWORD_KDF_DEFINES_SVH

`ifndef SYNTHESIS
// check that a condition holds at every edge out of reset
`define SDF_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("assertion failed");
// check a same-cycle implication
`define SDF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// check a next-cycle implication
`define SDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SDF_ASSERT(label, prop)
`define SDF_ASSERT_IMP(label, ante, cons)
`define SDF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* design/sdfkdf_pkg.sv */
// ----------------------------------------------------------------------------
// sdfkdf_pkg
// Shared types and constants of the salted dual-lane FNV password digest.
// ----------------------------------------------------------------------------
`default_nettype none

package sdfkdf_pkg;

    localparam logic [31:0] FNV_BASIS    = 32'd2166136261;
    localparam logic [31:0] PRIME_FIRST  = 32'd16777619;
    localparam logic [31:0] PRIME_SECOND = 32'd709607;
    localparam logic [31:0] MIX_MUL1     = 32'h7FEB352D;
    localparam logic [31:0] MIX_MUL2     = 32'h846CA68B;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // one decoded input word
    typedef struct packed {
        logic        kind_start;
        logic        byte_present;
        logic        end_of_message;
        logic [31:0] salt;
        logic [7:0]  data_byte;
        logic [31:0] expected_low;
        logic [31:0] expected_high;
    } op_t;

    // one result word
    typedef struct packed {
        logic [31:0] salt_out;
        logic [31:0] digest_low;
        logic [31:0] digest_high;
        logic        matches_res;
    } res_t;

endpackage

`default_nettype wire

/* design/sdfkdf_front.sv */
// ----------------------------------------------------------------------------
// sdfkdf_front
// Accepts input words, decodes them into commands and queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "salted_dual_fnv_password_kdf_defines.svh"

module sdfkdf_front
    import sdfkdf_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,
    input  wire logic         s_tlast,
    input  wire logic [1:0]   s_tuser,
    output op_t               q_head,
    output logic              q_valid,
    input  wire logic         q_pop
);

    op_t                q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] q_cnt_reg,  q_cnt_next;
    logic               push;
    op_t                op_in;

    // unpack the word into a command
    always_comb begin
        op_in.kind_start     = s_tuser[0];
        op_in.byte_present   = s_tuser[1];
        op_in.end_of_message = s_tlast;
        op_in.salt           = s_tdata[31:0];
        op_in.data_byte      = s_tdata[39:32];
        op_in.expected_low   = s_tdata[71:40];
        op_in.expected_high  = s_tdata[103:72];
    end

    assign s_tready = (q_cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (q_cnt_reg != '0);
    assign q_head   = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        q_cnt_next  = q_cnt_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        unique case ({push, q_pop})
            2'b10:   q_cnt_next = q_cnt_reg + 1'b1;
            2'b01:   q_cnt_next = q_cnt_reg - 1'b1;
            default: q_cnt_next = q_cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= op_in;
        end
    end

    `SDF_ASSERT(a_cnt_range, q_cnt_reg <= Q_CNT_W'(Q_DEPTH))
    `SDF_ASSERT(a_ptr_track, wr_ptr_reg == Q_PTR_W'(rd_ptr_reg + q_cnt_reg))
    `SDF_ASSERT_NEXT(a_cnt_grow, push && !q_pop, q_cnt_reg == Q_CNT_W'($past(q_cnt_reg) + 1'b1))

endmodule

`default_nettype wire

/* design/sdfkdf_back.sv */
// ----------------------------------------------------------------------------
// sdfkdf_back
// Runs queued commands: seeding, byte absorption, strengthening rounds, result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "salted_dual_fnv_password_kdf_defines.svh"

module sdfkdf_back
    import sdfkdf_pkg::*;
#(
    parameter int ROUNDS = 64
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire op_t  q_head,
    input  wire logic q_valid,
    output logic      q_pop,
    output res_t      res,
    output logic      m_valid,
    input  wire logic m_ready
);

    localparam int RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_SEED  = 14'b00000000000010,
        ST_MIX2  = 14'b00000000000100,
        ST_MIX3  = 14'b00000000001000,
        ST_SALT  = 14'b00000000010000,
        ST_BYTE  = 14'b00000000100000,
        ST_LOAD  = 14'b00000001000000,
        ST_LO1   = 14'b00000010000000,
        ST_LO2   = 14'b00000100000000,
        ST_ADD   = 14'b00001000000000,
        ST_HI1   = 14'b00010000000000,
        ST_HI2   = 14'b00100000000000,
        ST_HFOLD = 14'b01000000000000,
        ST_OUT   = 14'b10000000000000
    } state_t;

    function automatic logic [31:0] xs16(input logic [31:0] v);
        return v ^ (v >> 16);
    endfunction

    function automatic logic [31:0] xs15(input logic [31:0] v);
        return v ^ (v >> 15);
    endfunction

    // where to go once the byte step of a command is done
    function automatic state_t after_byte(input op_t op);
        return op.end_of_message ? ST_LOAD : ST_IDLE;
    endfunction

    function automatic state_t after_salt(input op_t op);
        return op.byte_present ? ST_BYTE : after_byte(op);
    endfunction

    state_t           state_reg,      state_next;
    op_t              cur_reg,        cur_next;
    logic [31:0]      acc_first_reg,  acc_first_next;
    logic [31:0]      acc_second_reg, acc_second_next;
    logic [31:0]      salt_hold_reg,  salt_hold_next;
    logic [31:0]      mix_reg,        mix_next;
    logic [31:0]      lo_reg,         lo_next;
    logic [31:0]      hi_reg,         hi_next;
    logic [31:0]      sum_reg,        sum_next;
    logic [RND_W-1:0] rnd_reg,        rnd_next;
    logic [1:0]       idx_reg,        idx_next;
    res_t             res_reg,        res_next;
    logic             m_valid_reg,    m_valid_next;

    logic [7:0]  salt_byte;
    logic [7:0]  absorb_b;
    logic [31:0] prod_a;
    logic [31:0] mul_opnd;
    logic [31:0] mul_k;
    logic [31:0] prod_b;
    logic [31:0] mix_fold;
    logic        out_free;

    assign salt_byte = 8'(cur_reg.salt >> {idx_reg, 3'b000});
    assign absorb_b  = (state_reg == ST_SALT) ? salt_byte : cur_reg.data_byte;
    assign mix_fold  = xs16(mix_reg);
    assign out_free  = !m_valid_reg || m_ready;

    // lane one multiplier: absorb only
    assign prod_a = (acc_first_reg ^ {24'd0, absorb_b}) * PRIME_FIRST;

    // lane two multiplier: absorb and every mixer multiply
    always_comb begin
        mul_opnd = xs16(cur_reg.salt);
        mul_k    = MIX_MUL1;
        unique case (state_reg)
            ST_SEED: begin
                mul_opnd = xs16(cur_reg.salt);
                mul_k    = MIX_MUL1;
            end
            ST_MIX2, ST_LO2, ST_HI2: begin
                mul_opnd = xs15(mix_reg);
                mul_k    = MIX_MUL2;
            end
            ST_SALT, ST_BYTE: begin
                mul_opnd = acc_second_reg ^ {24'd0, absorb_b};
                mul_k    = PRIME_SECOND;
            end
            ST_LO1: begin
                mul_opnd = xs16(lo_reg ^ hi_reg);
                mul_k    = MIX_MUL1;
            end
            ST_HI1: begin
                mul_opnd = xs16(sum_reg);
                mul_k    = MIX_MUL1;
            end
            default: begin
                mul_opnd = xs16(cur_reg.salt);
                mul_k    = MIX_MUL1;
            end
        endcase
    end

    assign prod_b = mul_opnd * mul_k;

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        acc_first_next  = acc_first_reg;
        acc_second_next = acc_second_reg;
        salt_hold_next  = salt_hold_reg;
        mix_next        = mix_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        sum_next        = sum_reg;
        rnd_next        = rnd_reg;
        idx_next        = idx_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        q_pop           = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    priority if (q_head.kind_start) begin
                        state_next = ST_SEED;
                    end else if (q_head.byte_present) begin
                        state_next = ST_BYTE;
                    end else if (q_head.end_of_message) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SEED: begin
                salt_hold_next = cur_reg.salt;
                acc_first_next = FNV_BASIS ^ cur_reg.salt;
                mix_next       = prod_b;
                state_next     = ST_MIX2;
            end
            ST_MIX2: begin
                mix_next   = prod_b;
                state_next = ST_MIX3;
            end
            ST_MIX3: begin
                acc_second_next = FNV_BASIS ^ mix_fold;
                idx_next        = 2'd0;
                state_next      = ST_SALT;
            end
            ST_SALT: begin
                acc_first_next  = prod_a;
                acc_second_next = prod_b;
                idx_next        = idx_reg + 2'd1;
                if (idx_reg == 2'd3) begin
                    state_next = after_salt(cur_reg);
                end
            end
            ST_BYTE: begin
                acc_first_next  = prod_a;
                acc_second_next = prod_b;
                state_next      = after_byte(cur_reg);
            end
            ST_LOAD: begin
                lo_next    = acc_first_reg;
                hi_next    = acc_second_reg;
                rnd_next   = '0;
                state_next = ST_LO1;
            end
            ST_LO1: begin
                mix_next   = prod_b;
                state_next = ST_LO2;
            end
            ST_LO2: begin
                mix_next   = prod_b;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                lo_next    = mix_fold;
                sum_next   = hi_reg + mix_fold + 32'(rnd_reg);
                state_next = ST_HI1;
            end
            ST_HI1: begin
                mix_next   = prod_b;
                state_next = ST_HI2;
            end
            ST_HI2: begin
                mix_next   = prod_b;
                state_next = ST_HFOLD;
            end
            ST_HFOLD: begin
                hi_next  = mix_fold;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == RND_LAST) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_LO1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    res_next.salt_out    = salt_hold_reg;
                    res_next.digest_low  = lo_reg;
                    res_next.digest_high = hi_reg;
                    res_next.matches_res = (lo_reg == cur_reg.expected_low)
                                        && (hi_reg == cur_reg.expected_high);
                    m_valid_next         = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            acc_first_reg  <= '0;
            acc_second_reg <= '0;
            salt_hold_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            acc_first_reg  <= acc_first_next;
            acc_second_reg <= acc_second_next;
            salt_hold_reg  <= salt_hold_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        mix_reg <= mix_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        sum_reg <= sum_next;
        rnd_reg <= rnd_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

    assign res     = res_reg;
    assign m_valid = m_valid_reg;

    `SDF_ASSERT_IMP(a_pop_idle, q_pop, state_reg == ST_IDLE)
    `SDF_ASSERT_NEXT(a_out_load, (state_reg == ST_OUT) && out_free, m_valid_reg && (state_reg == ST_IDLE))
    `SDF_ASSERT_NEXT(a_last_round, (state_reg == ST_HFOLD) && (rnd_reg == RND_LAST), state_reg == ST_OUT)

endmodule

`default_nettype wire

/* design/salted_dual_fnv_password_kdf.sv */
// ----------------------------------------------------------------------------
// salted_dual_fnv_password_kdf
// Salted dual-lane FNV-1a password digest with strengthening rounds.
// ----------------------------------------------------------------------------
// A password enters one byte per input word. A word with the start flag
// (s_tuser[0]) reseeds both FNV-1a lanes from its salt: lane one with the
// offset basis xor salt, lane two with the basis xor an avalanche of the salt;
// then the four salt bytes are absorbed, least significant first. A word with
// the byte flag (s_tuser[1]) absorbs its data byte; a word may carry none, so an
// empty password works. The word with s_tlast runs ROUNDS cross-mixing rounds
// on copies of the lanes and emits one result word: salt, both digest words,
// and in m_tuser whether they equal the expected words carried by that same
// input word. Words after an end without a new start keep absorbing.
// The back end takes a command only when idle and finishes it before the next:
// a start runs the avalanche and absorbs the four salt bytes, a byte word
// absorbs one byte, and the end word runs the rounds and loads the result.
// Lane two's single 32x32 multiplier serves absorption and every mixer
// multiply, one registered product per cycle. A two-word command queue
// lets the input side keep accepting while the back end works, and an output
// register holds a finished result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module salted_dual_fnv_password_kdf
    import sdfkdf_pkg::*;
#(
    parameter int ROUNDS = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // salt[31:0], data_byte[39:32], expected_low[71:40], expected_high[103:72]
    input  wire logic [103:0] s_tdata,
    // end_of_message
    input  wire logic         s_tlast,
    // kind_start[0], byte_present[1]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // salt_out[31:0], digest_low[63:32], digest_high[95:64]
    output logic [95:0]       m_tdata,
    // matches_res[0]
    output logic [0:0]        m_tuser
);

    op_t  q_head;
    logic q_valid;
    logic q_pop;
    res_t res;

    // accept and decode words, hold them in the queue
    sdfkdf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_head   (q_head),
        .q_valid  (q_valid),
        .q_pop    (q_pop)
    );

    // run the hash lanes and rounds, drive the result register
    sdfkdf_back #(
        .ROUNDS (ROUNDS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_head  (q_head),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .res     (res),
        .m_valid (m_tvalid),
        .m_ready (m_tready)
    );

    // pack the result word
    assign m_tdata = {res.digest_high, res.digest_low, res.salt_out};
    assign m_tuser = res.matches_res;

endmodule

`default_nettype wire

/* verif/tb_salted_dual_fnv_password_kdf.sv */
// ----------------------------------------------------------------------------
// tb_salted_dual_fnv_password_kdf
// Self-checking bench for the salted dual-lane FNV password digest: a short
// table of directed words, then random password messages, each result word
// checked against a bench-side model of both lanes and the strengthening rounds.
// ----------------------------------------------------------------------------

module tb_salted_dual_fnv_password_kdf
    import sdfkdf_pkg::*;
();

    localparam int STRENGTH_ROUNDS = 64;
    localparam int RANDOM_WORDS    = 1330;
    localparam int CALM_AFTER      = 1150;   // drop all idling past this many words
    localparam int HOLD_AT_WORD    = 200;    // start the long output hold-off here
    localparam int HOLD_CYCLES     = 2500;
    localparam int DRAIN_CYCLES    = 450;

    // how the expected digest of an end word is filled in
    typedef enum logic [1:0] {
        EXP_GIVEN,   // use exp_lo/exp_hi as written
        EXP_OWN,     // load the digest this word will produce: match must be 1
        EXP_NEAR     // same, with one bit flipped: match must be 0
    } exp_mode_t;

    typedef struct packed {
        logic        start;
        logic [31:0] salt;
        logic [7:0]  data;
        logic        present;
        logic        last;
        logic [31:0] exp_lo;
        logic [31:0] exp_hi;
        exp_mode_t   mode;
        logic        pin;        // 1: salt_out is typed in below
        logic [31:0] pin_salt;
    } pw_word_t;

    typedef struct packed {
        logic [31:0] lane_one;
        logic [31:0] lane_two;
        logic [31:0] salt_kept;
    } lanes_t;

    typedef struct packed {
        logic [31:0] salt;
        logic [31:0] lo;
        logic [31:0] hi;
        logic        match;
    } digest_t;

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [103:0]  s_tdata;
    logic          s_tlast;
    logic [1:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [95:0]   m_tdata;
    logic [0:0]    m_tuser;

    lanes_t        lanes;            // bench copy of both accumulators and the salt
    digest_t       digests_due[$];   // expected result words, oldest first
    int            mismatches;
    int            words_taken;
    int            content_words;
    int            digests_checked;
    int            verified_seen;
    bit            calm;

    always #5 aclk = ~aclk;

    salted_dual_fnv_password_kdf #(
        .ROUNDS(STRENGTH_ROUNDS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Bench model
    // ------------------------------------------------------------------------

    // xorshift-multiply avalanche
    function automatic logic [31:0] avalanche32(input logic [31:0] v);
        v = v ^ (v >> 16);
        v = v * MIX_MUL1;
        v = v ^ (v >> 15);
        v = v * MIX_MUL2;
        v = v ^ (v >> 16);
        return v;
    endfunction

    // Apply the start reseed, the four salt bytes and the password byte.
    function automatic lanes_t lanes_after(input lanes_t st, input pw_word_t w);
        logic [7:0] b;
        int         i;
        if (w.start) begin
            st.salt_kept = w.salt;
            st.lane_one  = FNV_BASIS ^ w.salt;
            st.lane_two  = FNV_BASIS ^ avalanche32(w.salt);
            for (i = 0; i < 4; i++) begin
                b = w.salt[8*i +: 8];
                st.lane_one = (st.lane_one ^ {24'd0, b}) * PRIME_FIRST;
                st.lane_two = (st.lane_two ^ {24'd0, b}) * PRIME_SECOND;
            end
        end
        if (w.present) begin
            st.lane_one = (st.lane_one ^ {24'd0, w.data}) * PRIME_FIRST;
            st.lane_two = (st.lane_two ^ {24'd0, w.data}) * PRIME_SECOND;
        end
        return st;
    endfunction

    // Cross-mix copies of both lanes; returns {hi, lo}.
    function automatic logic [63:0] strengthen(input lanes_t st);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] r;
        lo = st.lane_one;
        hi = st.lane_two;
        for (r = 0; r < STRENGTH_ROUNDS; r++) begin
            lo = avalanche32(lo ^ hi);
            hi = avalanche32(hi + lo + r);
        end
        return {hi, lo};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Sender: offer one word, wait for the handshake, then update the model
    // ------------------------------------------------------------------------
    task automatic send_word(input pw_word_t w);
        int          gap;
        int          flip;
        logic [63:0] peek;
        digest_t     due;
        // fill in the expected digest from the lanes as they will stand
        if (w.mode != EXP_GIVEN) begin
            peek     = strengthen(lanes_after(lanes, w));
            w.exp_lo = peek[31:0];
            w.exp_hi = peek[63:32];
            if (w.mode == EXP_NEAR) begin
                flip = $urandom_range(0, 63);
                if (flip < 32)
                    w.exp_lo[flip] = ~w.exp_lo[flip];
                else
                    w.exp_hi[flip-32] = ~w.exp_hi[flip-32];
            end
        end
        // idle burst on the input side
        gap = (!calm && $urandom_range(0, 9) == 0) ? $urandom_range(1, 18) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w.exp_hi, w.exp_lo, w.data, w.salt};
        s_tlast  <= w.last;
        s_tuser  <= {w.present, w.start};
        do @(posedge aclk); while (!s_tready);
        // word accepted: advance the model
        words_taken++;
        if (w.start || w.present || w.last)
            content_words++;
        lanes = lanes_after(lanes, w);
        if (w.last) begin
            peek      = strengthen(lanes);
            due.salt  = w.pin ? w.pin_salt : lanes.salt_kept;
            due.lo    = peek[31:0];
            due.hi    = peek[63:32];
            case (w.mode)
                EXP_OWN:  due.match = 1'b1;
                EXP_NEAR: due.match = 1'b0;
                default:  due.match = (peek == {w.exp_hi, w.exp_lo});
            endcase
            digests_due.push_back(due);
        end
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Directed table: start, salt, data, present, last, exp_lo, exp_hi, mode,
    // pin, pinned salt. Salt is typed in where it is plain from the history.
    // ------------------------------------------------------------------------
    pw_word_t directed_plan [0:18] = '{
        // end straight after reset: both lanes zero, salt zero
        '{1'b0, 32'h0, 8'h00, 1'b0, 1'b1, 32'h0, 32'h0, EXP_GIVEN, 1'b1, 32'h0},
        // zero byte into zero lanes, then end with its own digest
        '{1'b0, 32'h0, 8'h00, 1'b1, 1'b0, 32'h0, 32'h0, EXP_GIVEN, 1'b0, 32'h0},
        '{1'b0, 32'h0, 8'h00, 1'b0, 1'b1, 32'h0, 32'h0, EXP_OWN, 1'b1, 32'h0},
        // start and end together, empty password
        '{1'b1, 32'h0, 8'hFF, 1'b0, 1'b1, 32'h0, 32'h0, EXP_OWN, 1'b1, 32'h0},
        // start and end together, one byte, all-ones fields
        '{1'b1, '1, 8'hFF, 1'b1, 1'b1, '1, '1, EXP_GIVEN, 1'b1, '1},
        // plain message; the first word carries an ignored byte
        '{1'b1, 32'h12345678, 8'hA5, 1'b0, 1'b0, 32'h0, 32'h0, EXP_GIVEN, 1'b0, 32'h0},
        '{1'b0, 32'h0, 8'h00, 1'b1, 1'b0, 32'h0, 32'h0, EXP_GIVEN, 1'b0, 32'h0},
        '{1'b0, 32'h0, 8'hFF, 1'b1, 1'b0, 32'h0, 32'h0, EXP_GIVEN, 1'b0, 32'h0},
        '{1'b0, 32'h0, 8'h80, 1'b1, 1'b1, 32'h0, 32'h0, EXP_NEAR, 1'b1, 32'h12345678},
        // keep absorbing after the end without a new start
        '{1'b0, 32'h0, 8'h01, 1'b1, 1'b0, 32'h0, 32'h0, EXP_GIVEN, 1'b0, 32'h0},
        '{1'b0, 32'h0, 8'h00, 1'b0, 1'b1, 32'h0, 32'h0, EXP_OWN, 1'b1, 32'h12345678},
        // start abandoned by a second start
        '{1'b1, 32'h80000000, 8'h7F, 1'b1, 1'b0, 32'h0, 32'h0, EXP_GIVEN, 1'b0, 32'h0},
        '{1'b1, 32'h00000001, 8'h00, 1'b0, 1'b0, 32'h0, 32'h0, EXP_GIVEN, 1'b0, 32'h0},
        '{1'b0, 32'h0, 8'h55, 1'b1, 1'b0, 32'h0, 32'h0, EXP_GIVEN, 1'b0, 32'h0},
        '{1'b0, 32'h0, 8'hAA, 1'b1, 1'b1, 32'h0, '1, EXP_GIVEN, 1'b1, 32'h00000001},
        '{1'b1, 32'hDEADBEEF, 8'h3C, 1'b1, 1'b1, 32'h0, 32'h0, EXP_NEAR, 1'b1, 32'hDEADBEEF},
        // word with no flags at all
        '{1'b0, '1, 8'hFF, 1'b0, 1'b0, '1, '1, EXP_GIVEN, 1'b0, 32'h0},
        '{1'b0, 32'h0, 8'h00, 1'b0, 1'b1, 32'h0, 32'h0, EXP_OWN, 1'b1, 32'hDEADBEEF},
        '{1'b1, '1, 8'h00, 1'b0, 1'b1, '1, 32'h0, EXP_GIVEN, 1'b1, '1}
    };

    // ------------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        pw_word_t w;
        int       kind;
        int       len;
        int       n;
        int       rand_base;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        s_tuser  = '0;
        m_tready = 1'b0;
        lanes    = '0;
        calm     = 1'b0;
        mismatches      = 0;
        words_taken     = 0;
        content_words   = 0;
        digests_checked = 0;
        verified_seen   = 0;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_plan[i])
            send_word(directed_plan[i]);

        // random messages; count every accepted word
        rand_base = words_taken;
        while (words_taken - rand_base < RANDOM_WORDS) begin
            calm = (words_taken - rand_base) >= CALM_AFTER;
            kind = $urandom_range(0, 11);
            // mostly short passwords, now and then a long one
            len  = ($urandom_range(0, 19) == 0) ? $urandom_range(32, 64)
                                                : $urandom_range(0, 10);
            // random word body; flags set below per word
            w.salt    = $urandom;
            w.data    = 8'($urandom_range(0, 255));
            w.exp_lo  = $urandom;
            w.exp_hi  = $urandom;
            w.mode    = EXP_GIVEN;
            w.pin     = 1'b0;
            w.pin_salt = '0;
            if (kind == 0) begin
                // noise: any mix of flags
                w.start   = 1'($urandom_range(0, 1));
                w.present = 1'($urandom_range(0, 1));
                w.last    = 1'($urandom_range(0, 1));
                send_word(w);
            end else begin
                // kind 1: no start; kind 2: start but abandoned; else well formed
                w.start   = (kind != 1);
                w.present = 1'($urandom_range(0, 1));
                w.last    = (kind > 2 && len == 0 && $urandom_range(0, 1) == 1);
                if (w.last)
                    w.mode = exp_mode_t'($urandom_range(0, 2));
                send_word(w);
                for (n = 0; n < len && !w.last; n++) begin
                    w.start   = 1'b0;
                    w.salt    = $urandom;
                    w.data    = 8'($urandom_range(0, 255));
                    w.exp_lo  = $urandom;
                    w.exp_hi  = $urandom;
                    // hold the odd empty word inside the message
                    w.present = ($urandom_range(0, 7) != 0);
                    send_word(w);
                end
                if (!w.last && kind != 2) begin
                    w.start   = 1'b0;
                    w.salt    = $urandom;
                    w.data    = 8'($urandom_range(0, 255));
                    w.present = 1'($urandom_range(0, 1));
                    w.last    = 1'b1;
                    w.exp_lo  = $urandom;
                    w.exp_hi  = $urandom;
                    w.mode    = exp_mode_t'($urandom_range(0, 3) % 3);
                    send_word(w);
                end
            end
        end
        s_tvalid <= 1'b0;

        // drain, then keep watching for stray result words
        while (digests_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d input words (%0d with content), long output hold-off included.",
                 words_taken, content_words);
        $display("Checked %0d digest words, %0d of them verified matches.",
                 digests_checked, verified_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off to back up the input
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        bit held;
        stall_left = 0;
        held       = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && words_taken >= HOLD_AT_WORD) begin
                // hold off long enough for the queue and output register to fill
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each taken word with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        digest_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (digests_due.size() == 0) begin
                report_mismatch($sformatf("result word with nothing expected: %h/%b",
                                          m_tdata, m_tuser));
            end else begin
                due = digests_due.pop_front();
                digests_checked++;
                if (due.match)
                    verified_seen++;
                if (m_tdata[31:0] !== due.salt)
                    report_mismatch($sformatf("salt_out %h, want %h", m_tdata[31:0], due.salt));
                if (m_tdata[63:32] !== due.lo)
                    report_mismatch($sformatf("digest_low %h, want %h",
                                              m_tdata[63:32], due.lo));
                if (m_tdata[95:64] !== due.hi)
                    report_mismatch($sformatf("digest_high %h, want %h",
                                              m_tdata[95:64], due.hi));
                if (m_tuser[0] !== due.match)
                    report_mismatch($sformatf("matches_res %b, want %b",
                                              m_tuser[0], due.match));
            end
        end
    end

    // watchdog, several times the slowest legal run
    initial begin : watchdog
        #40_000_000;
        $display("Timeout with %0d result words still expected.", digests_due.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
